// ===== rtl/core/srht_pkg.sv =====
// ----------------------------------------------------------------------------
// srht_pkg: shared types and constants
// Field widths, event codes, the search item that travels along the cell
// row, and the result record of the state residency and hotspot table.
// ----------------------------------------------------------------------------
package srht_pkg;

    localparam int ST_W   = 2;
    localparam int TIME_W = 48;
    localparam int MOD_W  = 16;
    localparam int POS_W  = 32;
    localparam int LINE_W = 32;
    localparam int CNT_W  = 32;
    localparam int IDX_W  = 6;
    localparam int USED_W = 7;
    localparam int IDX_SPAN = 1 << IDX_W;

    localparam logic [ST_W-1:0] STATE_SCHED = 2'd2;

    typedef enum logic [1:0] {
        MODE_TRANS  = 2'd0,
        MODE_SAMPLE = 2'd1,
        MODE_START  = 2'd2,
        MODE_READ   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OP_NONE   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_BUSY = 2'd1,
        S_FIN  = 2'd2
    } t_ctl_state;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [MOD_W-1:0]  module_id;
        logic [POS_W-1:0]  position;
        logic              native;
        logic [LINE_W-1:0] line;
        logic [CNT_W-1:0]  count;
        logic [IDX_W-1:0]  idx;
        logic              done;
        logic              new_entry;
    } t_tok;

    typedef struct packed {
        logic [ST_W-1:0]   closed_state;
        logic [TIME_W-1:0] state_total;
        logic [IDX_W-1:0]  hit_index;
        logic [MOD_W-1:0]  hit_module;
        logic [POS_W-1:0]  hit_position;
        logic              hit_native;
        logic [LINE_W-1:0] hit_line;
        logic [CNT_W-1:0]  hit_count;
        logic              hit_valid;
        logic              new_entry;
        logic              sample_dropped;
        logic [USED_W-1:0] used_count;
    } t_result;

endpackage

// ===== rtl/core/srht_in_if.sv =====
// ----------------------------------------------------------------------------
// srht_in_if: event channel
// Valid/ready channel that carries one profiling event per item.
// ----------------------------------------------------------------------------
interface srht_in_if
    import srht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        mode;
    logic [TIME_W-1:0] now_time;
    logic [ST_W-1:0]   next_state;
    logic [MOD_W-1:0]  module_id;
    logic [POS_W-1:0]  position;
    logic              native;
    logic [LINE_W-1:0] line;
    logic [IDX_W-1:0]  entry_index;

    modport source (
        output valid, mode, now_time, next_state, module_id, position, native,
        line, entry_index,
        input  ready
    );
    modport sink (
        input  valid, mode, now_time, next_state, module_id, position, native,
        line, entry_index,
        output ready
    );
endinterface

// ===== rtl/core/srht_out_if.sv =====
// ----------------------------------------------------------------------------
// srht_out_if: result channel
// Valid/ready channel that carries one result item per event.
// ----------------------------------------------------------------------------
interface srht_out_if
    import srht_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   closed_state;
    logic [TIME_W-1:0] state_total;
    logic [IDX_W-1:0]  hit_index;
    logic [MOD_W-1:0]  hit_module;
    logic [POS_W-1:0]  hit_position;
    logic              hit_native;
    logic [LINE_W-1:0] hit_line;
    logic [CNT_W-1:0]  hit_count;
    logic              hit_valid;
    logic              new_entry;
    logic              sample_dropped;
    logic [USED_W-1:0] used_count;

    modport source (
        output valid, closed_state, state_total, hit_index, hit_module,
        hit_position, hit_native, hit_line, hit_count, hit_valid, new_entry,
        sample_dropped, used_count,
        input  ready
    );
    modport sink (
        input  valid, closed_state, state_total, hit_index, hit_module,
        hit_position, hit_native, hit_line, hit_count, hit_valid, new_entry,
        sample_dropped, used_count,
        output ready
    );
endinterface

// ===== rtl/core/srht_cell.sv =====
// ----------------------------------------------------------------------------
// srht_cell: one hotspot table entry
// Holds one entry, checks the passing search item against it, updates the
// count or takes a new entry, copies the entry into a read item that names
// it, and registers the item for the next cell.
module srht_cell
    import srht_pkg::*;
#(
    parameter int INDEX  = 0,
    parameter int USED_B = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [USED_B-1:0] i_used,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    localparam logic [USED_B-1:0] CellIdx = USED_B'(INDEX);
    localparam logic [IDX_W-1:0]  IdxBits = IDX_W'(INDEX);

    logic [MOD_W-1:0]  r_module;
    logic [POS_W-1:0]  r_position;
    logic              r_native;
    logic [LINE_W-1:0] r_line;
    logic [CNT_W-1:0]  r_count;
    t_tok              r_tok;
    t_tok              n_tok;

    logic              is_used;
    logic              match;
    logic              wr_hit;
    logic              wr_new;
    logic [CNT_W-1:0]  count_inc;

    assign is_used   = CellIdx < i_used;
    assign match     = (r_module == i_tok.module_id) && (r_position == i_tok.position) &&
                       (r_native == i_tok.native) && (r_line == i_tok.line);
    assign count_inc = (r_count == '1) ? r_count : r_count + CNT_W'(1);

    always_comb begin
        n_tok  = i_tok;
        wr_hit = 1'b0;
        wr_new = 1'b0;
        if (i_tok.valid && !i_tok.done) begin
            case (i_tok.op)
                OP_SAMPLE: begin
                    if (is_used && match) begin
                        wr_hit      = 1'b1;
                        n_tok.count = count_inc;
                        n_tok.idx   = IdxBits;
                        n_tok.done  = 1'b1;
                    end else if (CellIdx == i_used) begin
                        wr_new          = 1'b1;
                        n_tok.count     = CNT_W'(1);
                        n_tok.idx       = IdxBits;
                        n_tok.done      = 1'b1;
                        n_tok.new_entry = 1'b1;
                    end
                end
                OP_READ: begin
                    if (is_used && (INDEX < IDX_SPAN) && (i_tok.idx == IdxBits)) begin
                        n_tok.module_id = r_module;
                        n_tok.position  = r_position;
                        n_tok.native    = r_native;
                        n_tok.line      = r_line;
                        n_tok.count     = r_count;
                        n_tok.done      = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_new) begin
            r_module   <= i_tok.module_id;
            r_position <= i_tok.position;
            r_native   <= i_tok.native;
            r_line     <= i_tok.line;
            r_count    <= CNT_W'(1);
        end else if (wr_hit) begin
            r_count <= count_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.op        <= n_tok.op;
        r_tok.module_id <= n_tok.module_id;
        r_tok.position  <= n_tok.position;
        r_tok.native    <= n_tok.native;
        r_tok.line      <= n_tok.line;
        r_tok.count     <= n_tok.count;
        r_tok.idx       <= n_tok.idx;
        r_tok.done      <= n_tok.done;
        r_tok.new_entry <= n_tok.new_entry;
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/srht_chain.sv =====
// ----------------------------------------------------------------------------
// srht_chain: row of table cells
// Passes each search item from cell to cell, one cell per cycle.
// ----------------------------------------------------------------------------
module srht_chain
    import srht_pkg::*;
#(
    parameter int ENTRIES = 64,
    parameter int USED_B  = 7
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [USED_B-1:0] i_used,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    t_tok w_tok [0:ENTRIES];

    assign w_tok[0] = i_tok;

    for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
        srht_cell #(
            .INDEX  (g),
            .USED_B (USED_B)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_used  (i_used),
            .i_tok   (w_tok[g]),
            .o_tok   (w_tok[g+1])
        );
    end

    assign o_tok = w_tok[ENTRIES];

endmodule

// ===== rtl/core/state_residency_and_hotspot_table_unit.sv =====
// ----------------------------------------------------------------------------
// state_residency_and_hotspot_table_unit: state residency and hotspot table
// Keeps time spent in four activity states and a table of sampled code
// positions with saturating hit counts.
// ----------------------------------------------------------------------------
// Events arrive on i_in, one item each: transition, sample, start or read.
// Every event gives exactly one result item on o_out. The single enable
// register is written via i_cfg_we and i_cfg_wdata, by the user only while
// the block is idle (not enforced by the block); a start event also sets it.
// Each event walks the row of TABLE_ENTRIES cells, one cell per cycle, and
// the block takes no new event until the last one has left the row and its
// result has been written to the output register.
// The result sits in an output register; the next event is accepted while
// it waits. If the receiver stalls, the following event finishes its walk
// and then holds until the output register is free.
// Reset selects the scheduler state, clears the buckets, the enable, the
// last time stamp and the entry count. Table contents are not cleared; only
// entries below the entry count are ever reported.
// ----------------------------------------------------------------------------
module state_residency_and_hotspot_table_unit
    import srht_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_cfg_we,
    input  logic  i_cfg_wdata,
    srht_in_if.sink    i_in,
    srht_out_if.source o_out
);

    localparam int UW = $clog2(TABLE_ENTRIES + 1);

    t_ctl_state        r_state;
    t_ctl_state        n_state;

    logic              r_enabled;
    logic [ST_W-1:0]   r_cur;
    logic [TIME_W-1:0] r_last;
    logic [TIME_W-1:0] r_bucket [0:3];
    logic [UW-1:0]     r_used;

    t_mode             r_mode;
    logic              r_act;
    logic [TIME_W-1:0] r_now;
    logic [ST_W-1:0]   r_tgt;
    logic [TIME_W-1:0] r_elapsed;
    t_tok              r_fin;

    t_result           r_out;
    logic              r_out_valid;

    logic              accept;
    logic              out_free;
    logic              finish;
    t_mode             in_mode;
    t_tok              tok_in;
    t_tok              tok_tail;
    logic [ST_W-1:0]   bsel;
    logic [TIME_W-1:0] bval;
    logic [TIME_W:0]   sum_raw;
    logic [TIME_W-1:0] sum_sat;
    logic [UW-1:0]     used_next;
    t_result           res;

    assign in_mode  = t_mode'(i_in.mode);
    assign i_in.ready = (r_state == S_IDLE);
    assign accept   = i_in.valid && i_in.ready;
    assign out_free = !r_out_valid || o_out.ready;
    assign finish   = (r_state == S_FIN) && out_free;

    always_comb begin
        tok_in.valid     = accept;
        tok_in.op        = OP_NONE;
        tok_in.module_id = i_in.module_id;
        tok_in.position  = i_in.position;
        tok_in.native    = i_in.native;
        tok_in.line      = i_in.line;
        tok_in.count     = '0;
        tok_in.idx       = '0;
        tok_in.done      = 1'b0;
        tok_in.new_entry = 1'b0;
        if (in_mode == MODE_SAMPLE && r_enabled) begin
            tok_in.op = OP_SAMPLE;
        end else if (in_mode == MODE_READ) begin
            tok_in.op  = OP_READ;
            tok_in.idx = i_in.entry_index;
        end
    end

    srht_chain #(
        .ENTRIES (TABLE_ENTRIES),
        .USED_B  (UW)
    ) u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_used  (r_used),
        .i_tok   (tok_in),
        .o_tok   (tok_tail)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_BUSY;
                end
            end
            S_BUSY: begin
                if (tok_tail.valid) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= in_mode;
            r_act     <= r_enabled && (in_mode == MODE_TRANS || in_mode == MODE_SAMPLE);
            r_now     <= i_in.now_time;
            r_tgt     <= (in_mode == MODE_SAMPLE) ? STATE_SCHED : i_in.next_state;
            r_elapsed <= i_in.now_time - r_last;
        end
        if (r_state == S_BUSY && tok_tail.valid) begin
            r_fin <= tok_tail;
        end
    end

    assign bsel    = (r_mode == MODE_READ) ? r_tgt : r_cur;
    assign bval    = r_bucket[bsel];
    assign sum_raw = {1'b0, bval} + {1'b0, r_elapsed};
    assign sum_sat = sum_raw[TIME_W] ? '1 : sum_raw[TIME_W-1:0];
    assign used_next = (r_mode == MODE_START) ? '0 : r_used + UW'(r_fin.new_entry);

    always_comb begin
        res.closed_state   = bsel;
        res.state_total    = bval;
        if (r_mode == MODE_START) begin
            res.state_total = '0;
        end else if (r_act) begin
            res.state_total = sum_sat;
        end
        res.hit_index      = r_fin.idx;
        res.hit_module     = r_fin.done ? r_fin.module_id : '0;
        res.hit_position   = r_fin.done ? r_fin.position : '0;
        res.hit_native     = r_fin.done && r_fin.native;
        res.hit_line       = r_fin.done ? r_fin.line : '0;
        res.hit_count      = r_fin.done ? r_fin.count : '0;
        res.hit_valid      = r_fin.done;
        res.new_entry      = r_fin.new_entry;
        res.sample_dropped = r_act && (r_mode == MODE_SAMPLE) && !r_fin.done;
        res.used_count     = USED_W'(used_next);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_cur     <= STATE_SCHED;
            r_last    <= '0;
            r_used    <= '0;
            for (int k = 0; k < 4; k++) begin
                r_bucket[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (finish) begin
                r_used <= used_next;
                if (r_mode == MODE_START) begin
                    r_enabled <= 1'b1;
                    r_last    <= r_now;
                    for (int k = 0; k < 4; k++) begin
                        r_bucket[k] <= '0;
                    end
                end else if (r_act) begin
                    r_bucket[r_cur] <= sum_sat;
                    r_cur           <= r_tgt;
                    r_last          <= r_now;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (finish) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (finish) begin
            r_out <= res;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.closed_state   = r_out.closed_state;
    assign o_out.state_total    = r_out.state_total;
    assign o_out.hit_index      = r_out.hit_index;
    assign o_out.hit_module     = r_out.hit_module;
    assign o_out.hit_position   = r_out.hit_position;
    assign o_out.hit_native     = r_out.hit_native;
    assign o_out.hit_line       = r_out.hit_line;
    assign o_out.hit_count      = r_out.hit_count;
    assign o_out.hit_valid      = r_out.hit_valid;
    assign o_out.new_entry      = r_out.new_entry;
    assign o_out.sample_dropped = r_out.sample_dropped;
    assign o_out.used_count     = r_out.used_count;

endmodule

// ===== tb/tb_state_residency_and_hotspot_table_unit.sv =====
// ----------------------------------------------------------------------------
// tb_state_residency_and_hotspot_table_unit: self-checking testbench
// Drives profiling events (transitions, samples, starts and reads) into the
// state residency and hotspot table, predicts every result item with its own
// model of buckets and table, and compares each result field by field. Both
// channels idle at random, the receiver holds off long enough to stall the
// input, and the enable register is exercised between phases.
// ----------------------------------------------------------------------------
module tb_state_residency_and_hotspot_table_unit;
    import srht_pkg::*;

    localparam int TBL_N     = 64;
    localparam int CLK_HALF  = 6;
    localparam int DRAIN_CYC = TBL_N + 8;
    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX  = {CNT_W{1'b1}};

    typedef struct packed {
        logic [1:0]        mode;
        logic [TIME_W-1:0] now_time;
        logic [ST_W-1:0]   next_state;
        logic [MOD_W-1:0]  module_id;
        logic [POS_W-1:0]  position;
        logic              native;
        logic [LINE_W-1:0] line;
        logic [IDX_W-1:0]  entry_index;
    } t_profile_event;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    srht_in_if  ev_if ();
    srht_out_if res_if ();

    state_residency_and_hotspot_table_unit #(
        .TABLE_ENTRIES(TBL_N)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in       (ev_if),
        .o_out      (res_if)
    );

    // Predictor state.
    logic              prof_enabled;
    logic [ST_W-1:0]   prof_state;
    logic [TIME_W-1:0] prof_last_time;
    logic [TIME_W-1:0] prof_bucket [4];
    logic [MOD_W-1:0]  tbl_module [TBL_N];
    logic [POS_W-1:0]  tbl_position [TBL_N];
    logic              tbl_native [TBL_N];
    logic [LINE_W-1:0] tbl_line [TBL_N];
    logic [CNT_W-1:0]  tbl_count [TBL_N];
    int                tbl_used;

    t_result pending_results [$];

    // Sample keys reused within a phase so that matches happen.
    logic [MOD_W-1:0]  key_module [16];
    logic [POS_W-1:0]  key_position [16];
    logic              key_native [16];
    logic [LINE_W-1:0] key_line [16];

    logic [TIME_W-1:0] stim_time;
    int  items_sent;
    int  results_checked;
    int  mismatch_count;
    int  inserts;
    int  match_hits;
    int  drops;
    int  saturations;
    int  hold_req;
    bit  stall_on;
    bit  gap_on;

    initial begin
        i_clk = 1'b0;
    end

    always #(CLK_HALF) i_clk = ~i_clk;

    initial begin
        #(2 * CLK_HALF * 3_000_000);
        $display("Test completed with failures");
        $finish;
    end

    function automatic int idle_len();
        if ($urandom_range(99) < 85) begin
            return $urandom_range(4, 1);
        end
        return $urandom_range(150, 20);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        logic [63:0] wide;
        wide = {$urandom(), $urandom()};
        return wide[TIME_W-1:0];
    endfunction

    function automatic t_result close_residency(input t_result r,
                                                input logic [TIME_W-1:0] now,
                                                input logic [ST_W-1:0] nxt);
        logic [TIME_W:0] sum;
        sum = {1'b0, prof_bucket[prof_state]} + {1'b0, now - prof_last_time};
        if (sum[TIME_W]) begin
            sum = {1'b0, TIME_MAX};
            saturations++;
        end
        r.closed_state = prof_state;
        r.state_total = sum[TIME_W-1:0];
        prof_bucket[prof_state] = sum[TIME_W-1:0];
        prof_state = nxt;
        prof_last_time = now;
        return r;
    endfunction

    function automatic t_result entry_to_result(input t_result r, input int i);
        r.hit_index = i[IDX_W-1:0];
        r.hit_module = tbl_module[i];
        r.hit_position = tbl_position[i];
        r.hit_native = tbl_native[i];
        r.hit_line = tbl_line[i];
        r.hit_count = tbl_count[i];
        r.hit_valid = 1'b1;
        return r;
    endfunction

    function automatic t_result apply_profile_event(input t_profile_event ev);
        t_result r;
        int      found;
        r = '0;
        found = -1;
        r.closed_state = prof_state;
        r.state_total = prof_bucket[prof_state];
        if (ev.mode == MODE_TRANS) begin
            if (prof_enabled) begin
                r = close_residency(r, ev.now_time, ev.next_state);
            end
        end else if (ev.mode == MODE_SAMPLE) begin
            if (prof_enabled) begin
                for (int i = 0; i < tbl_used; i++) begin
                    if (tbl_module[i] == ev.module_id && tbl_position[i] == ev.position &&
                        tbl_native[i] == ev.native && tbl_line[i] == ev.line) begin
                        found = i;
                        break;
                    end
                end
                if (found >= 0) begin
                    if (tbl_count[found] != CNT_MAX) begin
                        tbl_count[found] = tbl_count[found] + 1'b1;
                    end
                    r = entry_to_result(r, found);
                    match_hits++;
                end else if (tbl_used < TBL_N) begin
                    tbl_module[tbl_used] = ev.module_id;
                    tbl_position[tbl_used] = ev.position;
                    tbl_native[tbl_used] = ev.native;
                    tbl_line[tbl_used] = ev.line;
                    tbl_count[tbl_used] = CNT_W'(1);
                    r = entry_to_result(r, tbl_used);
                    r.new_entry = 1'b1;
                    tbl_used++;
                    inserts++;
                end else begin
                    r.sample_dropped = 1'b1;
                    drops++;
                end
                r = close_residency(r, ev.now_time, STATE_SCHED);
            end
        end else if (ev.mode == MODE_START) begin
            for (int s = 0; s < 4; s++) begin
                prof_bucket[s] = '0;
            end
            tbl_used = 0;
            prof_last_time = ev.now_time;
            prof_enabled = 1'b1;
            r.state_total = '0;
        end else begin
            r.closed_state = ev.next_state;
            r.state_total = prof_bucket[ev.next_state];
            r.hit_index = ev.entry_index;
            if (int'(ev.entry_index) < tbl_used) begin
                r = entry_to_result(r, int'(ev.entry_index));
            end
        end
        r.used_count = tbl_used[USED_W-1:0];
        return r;
    endfunction

    task automatic send_event(input t_profile_event ev);
        ev_if.valid <= 1'b1;
        ev_if.mode <= ev.mode;
        ev_if.now_time <= ev.now_time;
        ev_if.next_state <= ev.next_state;
        ev_if.module_id <= ev.module_id;
        ev_if.position <= ev.position;
        ev_if.native <= ev.native;
        ev_if.line <= ev.line;
        ev_if.entry_index <= ev.entry_index;
        do begin
            @(posedge i_clk);
        end while (!ev_if.ready);
        pending_results.push_back(apply_profile_event(ev));
        items_sent++;
        if (gap_on && $urandom_range(99) < 25) begin
            ev_if.valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        ev_if.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        prof_enabled = value;
        i_cfg_we <= 1'b0;
    endtask

    function automatic t_profile_event make_event(input logic [1:0] mode,
                                                  input logic [TIME_W-1:0] now,
                                                  input logic [ST_W-1:0] nxt,
                                                  input logic [IDX_W-1:0] idx);
        t_profile_event ev;
        ev = '0;
        ev.mode = mode;
        ev.now_time = now;
        ev.next_state = nxt;
        ev.entry_index = idx;
        return ev;
    endfunction

    function automatic t_profile_event make_sample(input logic [TIME_W-1:0] now,
                                                   input logic [MOD_W-1:0] m,
                                                   input logic [POS_W-1:0] p,
                                                   input logic n,
                                                   input logic [LINE_W-1:0] l);
        t_profile_event ev;
        ev = make_event(MODE_SAMPLE, now, '0, '0);
        ev.module_id = m;
        ev.position = p;
        ev.native = n;
        ev.line = l;
        return ev;
    endfunction

    task automatic new_key_pool();
        for (int k = 0; k < 16; k++) begin
            if (k > 0 && $urandom_range(99) < 30) begin
                key_module[k] = key_module[k-1];
                key_position[k] = key_position[k-1];
                key_native[k] = ~key_native[k-1];
                key_line[k] = $urandom_range(1) ? '0 : key_line[k-1];
            end else begin
                key_module[k] = MOD_W'($urandom());
                key_position[k] = $urandom();
                key_native[k] = 1'($urandom_range(1));
                key_line[k] = $urandom_range(1) ? $urandom() : '0;
            end
        end
    endtask

    function automatic t_profile_event random_event(input int pool_size, input int start_pct);
        t_profile_event ev;
        int pick;
        int k;
        pick = $urandom_range(99);
        if ($urandom_range(99) < 80) begin
            stim_time = stim_time + $urandom_range(5000, 1);
        end else if ($urandom_range(99) < 75) begin
            stim_time = stim_time + {$urandom(), 8'h00};
        end else begin
            stim_time = rand_time();
        end
        ev.now_time = stim_time;
        ev.next_state = ST_W'($urandom_range(3));
        ev.module_id = MOD_W'($urandom());
        ev.position = $urandom();
        ev.native = 1'($urandom_range(1));
        ev.line = $urandom();
        if (tbl_used > 0 && $urandom_range(1)) begin
            ev.entry_index = IDX_W'($urandom_range(tbl_used - 1));
        end else begin
            ev.entry_index = IDX_W'($urandom_range(TBL_N - 1));
        end
        if (pick < start_pct) begin
            ev.mode = MODE_START;
        end else if (pick < 38) begin
            ev.mode = MODE_TRANS;
        end else if (pick < 80) begin
            ev.mode = MODE_SAMPLE;
            if (pool_size > 0 && $urandom_range(99) < 75) begin
                k = $urandom_range(pool_size - 1);
                ev.module_id = key_module[k];
                ev.position = key_position[k];
                ev.native = key_native[k];
                ev.line = key_line[k];
            end
        end else begin
            ev.mode = MODE_READ;
        end
        return ev;
    endfunction

    task automatic test_reset_defaults();
        send_event(make_event(MODE_READ, 48'd0, 2'd0, 6'd0));
        send_event(make_event(MODE_READ, TIME_MAX, 2'd3, 6'd63));
        send_event(make_event(MODE_TRANS, 48'd100, 2'd1, 6'd0));
        send_event(make_sample(48'd200, 16'h1234, 32'h55AA_55AA, 1'b1, 32'd7));
        write_enable(1'b1);
    endtask

    task automatic test_residency_extremes();
        send_event(make_event(MODE_TRANS, 48'd0, 2'd0, 6'd0));
        send_event(make_event(MODE_TRANS, TIME_MAX, 2'd0, 6'd0));
        send_event(make_event(MODE_TRANS, TIME_MAX - 1'b1, 2'd3, 6'd0));
        send_event(make_event(MODE_TRANS, 48'd5, 2'd1, 6'd0));
        for (int s = 0; s < 4; s++) begin
            send_event(make_event(MODE_READ, 48'd6, s[1:0], 6'd0));
        end
    endtask

    task automatic test_sample_matching();
        send_event(make_event(MODE_START, 48'd1000, 2'd0, 6'd0));
        send_event(make_sample(48'd1010, '1, '1, 1'b1, '1));
        send_event(make_sample(48'd1020, '1, '1, 1'b1, '1));
        send_event(make_sample(48'd1030, '1, '1, 1'b0, '1));
        send_event(make_sample(48'd1040, '1, '1, 1'b1, '0));
        send_event(make_sample(48'd1050, '0, '0, 1'b0, '0));
        send_event(make_event(MODE_READ, 48'd1060, 2'd2, 6'd0));
        send_event(make_event(MODE_READ, 48'd1060, 2'd2, 6'd4));
        send_event(make_event(MODE_READ, 48'd1060, 2'd1, 6'd5));
        send_event(make_event(MODE_READ, 48'd1060, 2'd0, 6'd63));
        write_enable(1'b0);
        send_event(make_sample(48'd1070, '1, '1, 1'b1, '1));
        send_event(make_event(MODE_TRANS, 48'd1080, 2'd3, 6'd0));
        send_event(make_event(MODE_START, 48'd1090, 2'd0, 6'd0));
    endtask

    task automatic test_table_full();
        t_profile_event ev;
        t_profile_event first_key;
        send_event(make_event(MODE_START, stim_time, 2'd0, 6'd0));
        for (int n = 0; n < TBL_N + 6; n++) begin
            stim_time = stim_time + $urandom_range(300, 1);
            ev = make_sample(stim_time, MOD_W'($urandom()), $urandom(),
                             1'($urandom_range(1)), $urandom());
            if (n == 0) begin
                first_key = ev;
            end
            send_event(ev);
        end
        first_key.now_time = stim_time + 48'd10;
        send_event(first_key);
        send_event(make_event(MODE_READ, stim_time, 2'd2, 6'd63));
        send_event(make_event(MODE_READ, stim_time, 2'd0, 6'd0));
    endtask

    task automatic test_output_backpressure();
        wait_drained();
        hold_req = 600;
        gap_on = 1'b0;
        for (int n = 0; n < 16; n++) begin
            send_event(random_event(16, 2));
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        logic phase_enable [8];
        int   pool_size;
        int   start_pct;
        phase_enable = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
        for (int ph = 0; ph < 8; ph++) begin
            write_enable(phase_enable[ph]);
            new_key_pool();
            case (ph % 3)
                0: begin
                    pool_size = 4;
                    start_pct = 3;
                end
                1: begin
                    pool_size = 16;
                    start_pct = 2;
                end
                default: begin
                    pool_size = 0;
                    start_pct = 0;
                end
            endcase
            stall_on = (ph != 3);
            gap_on = (ph != 4);
            for (int n = 0; n < 200; n++) begin
                send_event(random_event(pool_size, start_pct));
            end
        end
        stall_on = 1'b1;
        gap_on = 1'b1;
    endtask

    task automatic check_field(input string name, input logic [63:0] want_v,
                               input logic [63:0] got_v);
        if (want_v !== got_v) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Mismatch in result %0d, %s: expected %0h, got %0h",
                         results_checked, name, want_v, got_v);
            end
        end
    endtask

    task automatic check_result();
        t_result got;
        t_result want;
        got.closed_state = res_if.closed_state;
        got.state_total = res_if.state_total;
        got.hit_index = res_if.hit_index;
        got.hit_module = res_if.hit_module;
        got.hit_position = res_if.hit_position;
        got.hit_native = res_if.hit_native;
        got.hit_line = res_if.hit_line;
        got.hit_count = res_if.hit_count;
        got.hit_valid = res_if.hit_valid;
        got.new_entry = res_if.new_entry;
        got.sample_dropped = res_if.sample_dropped;
        got.used_count = res_if.used_count;
        results_checked++;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("Unexpected result %0d with no event outstanding", results_checked);
            end
        end else begin
            want = pending_results.pop_front();
            check_field("closed_state", 64'(want.closed_state), 64'(got.closed_state));
            check_field("state_total", 64'(want.state_total), 64'(got.state_total));
            check_field("hit_index", 64'(want.hit_index), 64'(got.hit_index));
            check_field("hit_module", 64'(want.hit_module), 64'(got.hit_module));
            check_field("hit_position", 64'(want.hit_position), 64'(got.hit_position));
            check_field("hit_native", 64'(want.hit_native), 64'(got.hit_native));
            check_field("hit_line", 64'(want.hit_line), 64'(got.hit_line));
            check_field("hit_count", 64'(want.hit_count), 64'(got.hit_count));
            check_field("hit_valid", 64'(want.hit_valid), 64'(got.hit_valid));
            check_field("new_entry", 64'(want.new_entry), 64'(got.new_entry));
            check_field("sample_dropped", 64'(want.sample_dropped),
                        64'(got.sample_dropped));
            check_field("used_count", 64'(want.used_count), 64'(got.used_count));
        end
    endtask

    // The receiver: checks accepted results and decides its own stalls.
    initial begin
        int hold_left;
        int stall_left;
        hold_left = 0;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                check_result();
            end
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if (stall_on && $urandom_range(99) < 12) begin
                    stall_left = idle_len();
                end
            end
        end
    end

    initial begin
        prof_enabled = 1'b0;
        prof_state = STATE_SCHED;
        prof_last_time = '0;
        for (int s = 0; s < 4; s++) begin
            prof_bucket[s] = '0;
        end
        tbl_used = 0;
        stim_time = '0;
        items_sent = 0;
        results_checked = 0;
        mismatch_count = 0;
        inserts = 0;
        match_hits = 0;
        drops = 0;
        saturations = 0;
        hold_req = 0;
        stall_on = 1'b1;
        gap_on = 1'b1;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_wdata <= 1'b0;
        ev_if.valid <= 1'b0;
        ev_if.mode <= '0;
        ev_if.now_time <= '0;
        ev_if.next_state <= '0;
        ev_if.module_id <= '0;
        ev_if.position <= '0;
        ev_if.native <= 1'b0;
        ev_if.line <= '0;
        ev_if.entry_index <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_residency_extremes();
        test_sample_matching();
        test_table_full();
        test_output_backpressure();
        test_random_phases();
        wait_drained();

        $display("Summary: %0d events sent, %0d results checked, %0d mismatches.",
                 items_sent, results_checked, mismatch_count);
        $display("Covered %0d inserts, %0d matches, %0d dropped samples, %0d saturated buckets.",
                 inserts, match_hits, drops, saturations);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/srht_pkg.sv
rtl/core/srht_in_if.sv
rtl/core/srht_out_if.sv
rtl/core/srht_cell.sv
rtl/core/srht_chain.sv
rtl/core/state_residency_and_hotspot_table_unit.sv
tb/tb_state_residency_and_hotspot_table_unit.sv
